FILE: rtl/urbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbe_pkg
// shared constants, types and pointer helpers for the uart ring buffer engine
// ----------------------------------------------------------------------------
package urbe_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int M_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_PUT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RECV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TXE  = 3'd4;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic scan;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic read_wait;
        logic scan_start;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    function automatic ptr_t ptr_adv(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic logic [7:0] ptr_low8(input ptr_t p);
        logic [31:0] w;
        w = 32'(p);
        return w[7:0];
    endfunction

endpackage

FILE: rtl/urbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbe_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module urbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/urbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbe_ctrl
// sequencing state machine: accept, execute, memory read wait, peek scan, output load
// ----------------------------------------------------------------------------
module urbe_ctrl
    import urbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_WAIT = 5'b00100,
        S_SCAN = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.read_wait)
                begin
                    state_next = S_WAIT;
                end
                else if (stat.scan_start)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_WAIT:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_LOAD;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/urbe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urbe_dp
// fifo pointers, interrupt enables, both byte stores, result staging and output register
// ----------------------------------------------------------------------------
module urbe_dp
    import urbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_stat_t            stat,
    input  logic [KIND_W-1:0]   s_tuser,
    input  logic [BYTE_W-1:0]   s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] byte_reg;

    ptr_t tx_wp_reg, tx_wp_next;
    ptr_t tx_rp_reg, tx_rp_next;
    ptr_t rx_wp_reg, rx_wp_next;
    ptr_t rx_rp_reg, rx_rp_next;
    ptr_t cursor_reg, cursor_next;
    logic rx_en_reg, rx_en_next;
    logic tx_en_reg, tx_en_next;

    logic        st_status_reg;
    logic [7:0]  st_rd_reg;
    logic [7:0]  st_pos_reg;
    logic        st_sv_reg;
    logic [7:0]  st_sb_reg;

    logic        fin_we;
    logic        fin_status;
    logic [7:0]  fin_rd;
    logic [7:0]  fin_pos;
    logic        fin_sv;
    logic [7:0]  fin_sb;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic              tx_we, tx_re, rx_we, rx_re;
    ptr_t              rx_raddr;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;
    ptr_t              scan_nxt;

    assign scan_nxt = ptr_adv(cursor_reg);

    always_comb
    begin
        tx_wp_next  = tx_wp_reg;
        tx_rp_next  = tx_rp_reg;
        rx_wp_next  = rx_wp_reg;
        rx_rp_next  = rx_rp_reg;
        cursor_next = cursor_reg;
        rx_en_next  = rx_en_reg;
        tx_en_next  = tx_en_reg;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        rx_raddr    = rx_rp_reg;
        fin_we      = 1'b0;
        fin_status  = STATUS_FAIL;
        fin_rd      = '0;
        fin_pos     = '0;
        fin_sv      = 1'b0;
        fin_sb      = '0;
        stat        = '0;

        if (cmd.exec)
        begin
            fin_we = 1'b1;
            case (kind_reg)
                KIND_PUT:
                begin
                    if (ptr_adv(tx_wp_reg) != tx_rp_reg)
                    begin
                        tx_we      = 1'b1;
                        tx_wp_next = ptr_adv(tx_wp_reg);
                        tx_en_next = 1'b1;
                        fin_status = STATUS_DONE;
                    end
                end
                KIND_GET:
                begin
                    if (rx_wp_reg != rx_rp_reg)
                    begin
                        rx_re          = 1'b1;
                        stat.read_wait = 1'b1;
                        fin_we         = 1'b0;
                    end
                end
                KIND_PEEK:
                begin
                    if (rx_wp_reg != rx_rp_reg)
                    begin
                        rx_re           = 1'b1;
                        cursor_next     = rx_rp_reg;
                        stat.scan_start = 1'b1;
                        fin_we          = 1'b0;
                    end
                end
                KIND_RECV:
                begin
                    if (rx_en_reg)
                    begin
                        rx_we      = 1'b1;
                        rx_wp_next = ptr_adv(rx_wp_reg);
                        if (ptr_adv(ptr_adv(rx_wp_reg)) == rx_rp_reg)
                        begin
                            rx_en_next = 1'b0;
                        end
                        fin_status = STATUS_DONE;
                    end
                end
                KIND_TXE:
                begin
                    if (tx_en_reg)
                    begin
                        tx_re          = 1'b1;
                        stat.read_wait = 1'b1;
                        fin_we         = 1'b0;
                    end
                end
                default:
                begin
                    fin_status = STATUS_FAIL;
                end
            endcase
        end

        if (cmd.fetch)
        begin
            fin_we     = 1'b1;
            fin_status = STATUS_DONE;
            if (kind_reg == KIND_GET)
            begin
                fin_rd     = rx_rdata;
                rx_rp_next = ptr_adv(rx_rp_reg);
                rx_en_next = 1'b1;
            end
            else
            begin
                fin_sv     = 1'b1;
                fin_sb     = tx_rdata;
                tx_rp_next = ptr_adv(tx_rp_reg);
                if (tx_wp_reg == ptr_adv(tx_rp_reg))
                begin
                    tx_en_next = 1'b0;
                end
            end
        end

        if (cmd.scan)
        begin
            if (rx_rdata == byte_reg)
            begin
                fin_we         = 1'b1;
                fin_status     = STATUS_DONE;
                fin_pos        = ptr_low8(cursor_reg);
                stat.scan_done = 1'b1;
            end
            else if (scan_nxt == rx_wp_reg)
            begin
                fin_we         = 1'b1;
                stat.scan_done = 1'b1;
            end
            else
            begin
                rx_re       = 1'b1;
                rx_raddr    = scan_nxt;
                cursor_next = scan_nxt;
            end
        end

        stat.out_free = !out_valid_reg || m_tready;
    end

    urbe_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (byte_reg),
        .re    (tx_re),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    urbe_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wp_reg),
        .wdata (byte_reg),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            cursor_reg    <= '0;
            rx_en_reg     <= 1'b1;
            tx_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tx_wp_reg  <= tx_wp_next;
            tx_rp_reg  <= tx_rp_next;
            rx_wp_reg  <= rx_wp_next;
            rx_rp_reg  <= rx_rp_next;
            cursor_reg <= cursor_next;
            rx_en_reg  <= rx_en_next;
            tx_en_reg  <= tx_en_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
        if (fin_we)
        begin
            st_status_reg <= fin_status;
            st_rd_reg     <= fin_rd;
            st_pos_reg    <= fin_pos;
            st_sv_reg     <= fin_sv;
            st_sb_reg     <= fin_sb;
        end
        if (cmd.load)
        begin
            out_data_reg <= {4'b0000, tx_en_reg, rx_en_reg, st_sb_reg, st_sv_reg,
                             st_pos_reg, st_rd_reg, st_status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/uart_ring_buffer_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine_unit
// one uart port with transmit and receive circular fifos and interrupt enables
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tuser kind, tdata data_byte
//  m_*       out        tdata status, read_byte, found_position, sent_valid,
//                       sent_byte, rx_irq_enabled, tx_irq_enabled
//
//  put, receive and failing items go from execute straight to output load, get and
//  transmitter empty add one registered read of a byte store, and a peek compares
//  the unread receive entries one per cycle until a match or the last entry
//  the next item is taken while the last result waits in the output register
//  a finished item holds and s_tready stays low until the output register frees
//  reset clears both fifos and enables receive; the stores are not cleared
// ----------------------------------------------------------------------------
module uart_ring_buffer_engine_unit
    import urbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // data_byte
    input  logic [2:0]          s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status, read_byte, found_position,
                                           // sent_valid, sent_byte, rx_irq_enabled,
                                           // tx_irq_enabled, zero pad
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    urbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    urbe_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
